// ===== rtl/csps_pkg.sv =====
// csps_pkg: shared types and codes for the capacitance sensor poll sequencer
// tick and result layouts, sequencer phases, command and mode codes, config indexes
// no dependencies
`timescale 1ns / 1ps

package csps_pkg;

	localparam int TIMER_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_ENDED     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_INTERLEAVE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_PERIOD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CONVERSION_SPEED = 3'd5;

	localparam int TICK_W   = 10;
	localparam int RESULT_W = 13;
	localparam int TDATA_W  = 16;

	typedef enum logic [3:0] {
		PH_POR      = 4'd0,
		PH_IDLE     = 4'd1,
		PH_RESET    = 4'd2,
		PH_INIT     = 4'd3,
		PH_TCAP     = 4'd4,
		PH_CAPWAIT  = 4'd5,
		PH_TTEMP    = 4'd6,
		PH_TEMPWAIT = 4'd7,
		PH_READTH   = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE      = 3'd0,
		CMD_RESET     = 3'd1,
		CMD_INIT      = 3'd2,
		CMD_CAP_TRIG  = 3'd3,
		CMD_TEMP_TRIG = 3'd4,
		CMD_READ      = 3'd5,
		CMD_HUM_DET   = 3'd6,
		CMD_HUM_READ  = 3'd7
	} cmd_t;

	localparam logic [1:0] MODE_DIFF = 2'd0;
	localparam logic [1:0] MODE_C1   = 2'd1;
	localparam logic [1:0] MODE_C2   = 2'd2;
	localparam logic [1:0] MODE_TEMP = 2'd3;

	localparam logic [1:0] DEM_UNKNOWN = 2'd0;
	localparam logic [1:0] DEM_SET_A   = 2'd1;
	localparam logic [1:0] DEM_SET_B   = 2'd2;

	localparam logic [1:0] SPEED_SLOW = 2'd2;

	localparam logic [2:0] PULSE_NONE = 3'd0;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// first member sits in the highest bits, so fields are listed top down
	typedef struct packed {
		logic [1:0] relay_c_demand;
		logic [1:0] relay_b_demand;
		logic [1:0] relay_a_demand;
		logic       hum_read_ok;
		logic       hum_detect_ok;
		logic       bus_ok;
		logic       ready_event;
	} tick_t;

	typedef struct packed {
		logic       hum_connected;
		logic       cap_connected;
		logic       expander_config;
		logic [2:0] relay_pulse;
		logic [1:0] conv_time_code;
		logic [1:0] conv_mode;
		cmd_t       command;
	} result_t;

	typedef struct packed {
		logic        sensor_enable;
		logic        single_ended_enable;
		logic [7:0]  temp_interleave_count;
		logic [15:0] ready_timeout_ticks;
		logic [15:0] humidity_period_ticks;
		logic [1:0]  conversion_speed;
	} cfg_t;

	typedef struct packed {
		logic [2:0] pulse;
		logic       cfg;
		logic       exp_ready;
		logic [2:0] upd;
	} relay_res_t;

endpackage

// ===== rtl/csps_relay.sv =====
// csps_relay: relay service decision for one idle tick
// picks the first relay whose demand differs and the pulse to drive
// depends on csps_pkg
`timescale 1ns / 1ps

module csps_relay (
	input  logic [2:0][1:0]       dem,
	input  logic [2:0][1:0]       applied,
	input  logic                  bus_ok,
	input  logic                  exp_ready,
	output csps_pkg::relay_res_t  res
);

	logic [2:0] differ;
	logic       go;
	logic [1:0] sel_dem;
	logic [1:0] sel_idx;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			differ[i] = dem[i] != applied[i];
		end
		// expander needs configuring first; a failed configure transfer stops the service
		go = exp_ready | bus_ok;

		res.cfg       = ~exp_ready;
		res.exp_ready = go;
		res.upd       = 3'b000;
		res.pulse     = csps_pkg::PULSE_NONE;
		sel_dem       = dem[0];
		sel_idx       = 2'd0;

		if (differ[0]) begin
			sel_dem = dem[0];
			sel_idx = 2'd0;
		end else if (differ[1]) begin
			sel_dem = dem[1];
			sel_idx = 2'd1;
		end else begin
			sel_dem = dem[2];
			sel_idx = 2'd2;
		end

		if (go) begin
			res.upd = {differ[2] & ~differ[1] & ~differ[0], differ[1] & ~differ[0], differ[0]};
			if (sel_dem == csps_pkg::DEM_SET_A || sel_dem == csps_pkg::DEM_SET_B) begin
				res.pulse = {sel_idx, 1'b0} + {1'b0, sel_dem};
			end
			if (differ == 3'b000) begin
				res.pulse = csps_pkg::PULSE_NONE;
			end
		end
	end

endmodule

// ===== rtl/csps_core.sv =====
// csps_core: sequencer state, tick timers and per-tick result logic
// state advances on every accepted tick; result is combinational for the output register
// depends on csps_pkg and csps_relay
`timescale 1ns / 1ps

module csps_core #(
	parameter int TIMER_BITS = csps_pkg::TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  csps_pkg::cfg_t       cfg,
	input  csps_pkg::tick_t      tick,
	output csps_pkg::result_t    result
);

	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	csps_pkg::phase_t phase_q, phase_d;
	logic [1:0]       cur_mode_q, cur_mode_d;
	logic [1:0]       prev_mode_q, prev_mode_d;
	logic [7:0]       count_q, count_d;
	logic             cap_up_q, cap_up_d;
	logic             hum_up_q, hum_up_d;
	logic             exp_ready_q, exp_ready_d;
	logic             latch_q, latch_d;
	logic [2:0][1:0]  applied_q, applied_d;
	logic [TIMER_BITS-1:0] rdy_el_q, rdy_el_d;
	logic [TIMER_BITS-1:0] hum_el_q, hum_el_d;

	logic [TIMER_BITS-1:0] rdy_inc, hum_inc;
	logic                  rdy_expired, hum_expired;
	logic [2:0][1:0]       dem;
	logic                  any_differ;
	logic                  hum_tmp;
	logic [1:0]            nx_mode;
	csps_pkg::relay_res_t  relay_res;

	assign dem = {tick.relay_c_demand, tick.relay_b_demand, tick.relay_a_demand};

	csps_relay u_relay (
		.dem       (dem),
		.applied   (applied_q),
		.bus_ok    (tick.bus_ok),
		.exp_ready (exp_ready_q),
		.res       (relay_res)
	);

	always_comb begin
		rdy_inc = (rdy_el_q == '1) ? rdy_el_q : rdy_el_q + 1'b1;
		hum_inc = (hum_el_q == '1) ? hum_el_q : hum_el_q + 1'b1;
		rdy_expired = CMP_W'(rdy_inc) >= CMP_W'(cfg.ready_timeout_ticks);
		hum_expired = CMP_W'(hum_inc) >= CMP_W'(cfg.humidity_period_ticks);
		any_differ  = dem != applied_q;
		nx_mode = (prev_mode_q == csps_pkg::MODE_C1) ? csps_pkg::MODE_C2 :
		          (prev_mode_q == csps_pkg::MODE_C2) ? csps_pkg::MODE_DIFF : csps_pkg::MODE_C1;
		hum_tmp = hum_up_q;

		phase_d     = phase_q;
		cur_mode_d  = cur_mode_q;
		prev_mode_d = prev_mode_q;
		count_d     = count_q;
		cap_up_d    = cap_up_q;
		hum_up_d    = hum_up_q;
		exp_ready_d = exp_ready_q;
		latch_d     = latch_q | tick.ready_event;
		applied_d   = applied_q;
		rdy_el_d    = rdy_inc;
		hum_el_d    = hum_inc;

		result = '0;

		if (cfg.sensor_enable) begin
			result.cap_connected = cap_up_q;
			result.hum_connected = hum_up_q;
			case (phase_q)
				csps_pkg::PH_IDLE: begin
					if (cap_up_q) begin
						if (any_differ) begin
							result.relay_pulse     = relay_res.pulse;
							result.expander_config = relay_res.cfg;
							exp_ready_d            = relay_res.exp_ready;
							for (int i = 0; i < 3; i++) begin
								if (relay_res.upd[i]) begin
									applied_d[i] = dem[i];
								end
							end
						end
						if (count_q < cfg.temp_interleave_count) begin
							phase_d = csps_pkg::PH_TCAP;
						end else if (hum_expired) begin
							phase_d = csps_pkg::PH_READTH;
						end else begin
							phase_d = csps_pkg::PH_TTEMP;
						end
					end else begin
						phase_d = csps_pkg::PH_RESET;
					end
				end
				csps_pkg::PH_RESET: begin
					latch_d        = 1'b0;
					result.command = csps_pkg::CMD_RESET;
					cap_up_d       = tick.bus_ok;
					phase_d        = tick.bus_ok ? csps_pkg::PH_INIT : csps_pkg::PH_IDLE;
				end
				csps_pkg::PH_INIT: begin
					result.command = csps_pkg::CMD_INIT;
					if (!tick.bus_ok) begin
						cap_up_d = 1'b0;
					end
					exp_ready_d = 1'b0;
					phase_d     = csps_pkg::PH_IDLE;
				end
				csps_pkg::PH_TCAP: begin
					latch_d = 1'b0;
					if (cfg.single_ended_enable) begin
						cur_mode_d  = nx_mode;
						prev_mode_d = nx_mode;
					end else begin
						cur_mode_d = csps_pkg::MODE_DIFF;
					end
					result.command        = csps_pkg::CMD_CAP_TRIG;
					result.conv_mode      = cur_mode_d;
					result.conv_time_code = (cfg.conversion_speed >= csps_pkg::SPEED_SLOW) ?
					                        csps_pkg::SPEED_SLOW : cfg.conversion_speed;
					if (tick.bus_ok) begin
						phase_d = csps_pkg::PH_CAPWAIT;
					end else begin
						cap_up_d = 1'b0;
						phase_d  = csps_pkg::PH_IDLE;
					end
					rdy_el_d = '0;
				end
				csps_pkg::PH_CAPWAIT, csps_pkg::PH_TEMPWAIT: begin
					if (rdy_expired) begin
						phase_d = csps_pkg::PH_POR;
					end else if (latch_d) begin
						result.command   = csps_pkg::CMD_READ;
						result.conv_mode = cur_mode_q;
						if (phase_q == csps_pkg::PH_CAPWAIT && count_q < csps_pkg::COUNT_MAX) begin
							count_d = count_q + 8'd1;
						end
						phase_d = csps_pkg::PH_IDLE;
					end
				end
				csps_pkg::PH_TTEMP: begin
					latch_d          = 1'b0;
					count_d          = '0;
					cur_mode_d       = csps_pkg::MODE_TEMP;
					result.command   = csps_pkg::CMD_TEMP_TRIG;
					result.conv_mode = csps_pkg::MODE_TEMP;
					if (tick.bus_ok) begin
						rdy_el_d = '0;
						phase_d  = csps_pkg::PH_TEMPWAIT;
					end else begin
						cap_up_d = 1'b0;
						phase_d  = csps_pkg::PH_IDLE;
					end
				end
				csps_pkg::PH_READTH: begin
					if (!hum_up_q) begin
						result.command = csps_pkg::CMD_HUM_DET;
						hum_tmp        = tick.hum_detect_ok;
					end else begin
						result.command = csps_pkg::CMD_HUM_READ;
					end
					hum_up_d = hum_tmp & tick.hum_read_ok;
					hum_el_d = '0;
					phase_d  = csps_pkg::PH_IDLE;
				end
				default: begin
					// power-on: drop both links and restart the timers
					cap_up_d = 1'b0;
					hum_up_d = 1'b0;
					rdy_el_d = '0;
					hum_el_d = '0;
					phase_d  = csps_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= csps_pkg::PH_POR;
			cur_mode_q  <= csps_pkg::MODE_DIFF;
			prev_mode_q <= csps_pkg::MODE_DIFF;
			count_q     <= '0;
			cap_up_q    <= 1'b0;
			hum_up_q    <= 1'b0;
			exp_ready_q <= 1'b0;
			latch_q     <= 1'b0;
			applied_q   <= '0;
			rdy_el_q    <= '0;
			hum_el_q    <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			cur_mode_q  <= cur_mode_d;
			prev_mode_q <= prev_mode_d;
			count_q     <= count_d;
			cap_up_q    <= cap_up_d;
			hum_up_q    <= hum_up_d;
			exp_ready_q <= exp_ready_d;
			latch_q     <= latch_d;
			applied_q   <= applied_d;
			rdy_el_q    <= rdy_el_d;
			hum_el_q    <= hum_el_d;
		end
	end

endmodule

// ===== rtl/cap_sensor_poll_sequencer.sv =====
// Capacitance sensor poll sequencer, one tick item in, one command item out.
//
// s_* channel: one transfer per 10 ms tick carrying the ready event, this tick's
// bus status flags and the three relay position demands.
// m_* channel: one result per tick: command, conversion mode, conversion time
// code, relay pulse, expander configure flag and both link flags.
// cfg_we/cfg_index/cfg_data: register writes, taken on any edge with cfg_we high;
// write only while no tick result is outstanding.
// The result of a tick is on m_tdata in the cycle after its transfer.
// One tick per cycle unless the receiver stalls; the whole sequencer step is a single pass of
// logic between the sequencer state registers and the output register.
// The output register lets a new tick in whenever it is empty or being drained
// in the same cycle; while the receiver stalls with a result held, s_tready is
// low and the sequencer state does not move.
// Reset puts the sequencer in power-on, clears links, counters and timers and
// loads the register defaults; no clearing pass is needed.
// depends on csps_pkg, csps_core, csps_relay
`timescale 1ns / 1ps

module cap_sensor_poll_sequencer #(
	parameter int TIMER_BITS = csps_pkg::TIMER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// ready_event, bus_ok, hum_detect_ok, hum_read_ok, relay_a_demand[1:0],
	// relay_b_demand[1:0], relay_c_demand[1:0], zero fill
	input  logic [csps_pkg::TDATA_W-1:0]    s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// command[2:0], conv_mode[1:0], conv_time_code[1:0], relay_pulse[2:0],
	// expander_config, cap_connected, hum_connected, zero fill
	output logic [csps_pkg::TDATA_W-1:0]    m_tdata,
	input  logic                            cfg_we,
	input  logic [csps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csps_pkg::CFG_DATA_W-1:0] cfg_data
);

	csps_pkg::cfg_t    cfg_q;
	csps_pkg::tick_t   tick;
	csps_pkg::result_t result, out_q;
	logic              out_valid_q;
	logic              accept;

	assign tick     = csps_pkg::tick_t'(s_tdata[csps_pkg::TICK_W-1:0]);
	assign s_tready = ~out_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(csps_pkg::TDATA_W - csps_pkg::RESULT_W){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_enable         <= 1'b1;
			cfg_q.single_ended_enable   <= 1'b0;
			cfg_q.temp_interleave_count <= 8'd16;
			cfg_q.ready_timeout_ticks   <= 16'd20;
			cfg_q.humidity_period_ticks <= 16'd100;
			cfg_q.conversion_speed      <= csps_pkg::SPEED_SLOW;
		end else if (cfg_we) begin
			case (cfg_index)
				csps_pkg::REG_SENSOR_ENABLE:    cfg_q.sensor_enable         <= cfg_data[0];
				csps_pkg::REG_SINGLE_ENDED:     cfg_q.single_ended_enable   <= cfg_data[0];
				csps_pkg::REG_TEMP_INTERLEAVE:  cfg_q.temp_interleave_count <= cfg_data[7:0];
				csps_pkg::REG_READY_TIMEOUT:    cfg_q.ready_timeout_ticks   <= cfg_data;
				csps_pkg::REG_HUMIDITY_PERIOD:  cfg_q.humidity_period_ticks <= cfg_data;
				csps_pkg::REG_CONVERSION_SPEED: cfg_q.conversion_speed      <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	csps_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.cfg     (cfg_q),
		.tick    (tick),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	// every accepted tick leaves a result in the output register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted tick produced no result");

	// a held result blocks the next tick
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("tick taken while result stalled");

	// a tick taken while sensing is disabled reports all zero
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_q.sensor_enable) |=> (m_tdata == '0))
		else $error("disabled tick gave a non-zero result");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for cap_sensor_poll_sequencer, tick stream in and command stream out
// predicts each tick result with its own sequencer copy and checks them in order
// depends on csps_pkg and the cap_sensor_poll_sequencer rtl
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_REPORTS     = 10;
	localparam int TICK_BITS       = csps_pkg::TICK_W;
	localparam int DATA_BITS       = csps_pkg::CFG_DATA_W;

	localparam logic [1:0] DM_UNK = csps_pkg::DEM_UNKNOWN;
	localparam logic [1:0] DM_A   = csps_pkg::DEM_SET_A;
	localparam logic [1:0] DM_B   = csps_pkg::DEM_SET_B;
	// demand code outside the defined set, must be taken without a pulse
	localparam logic [1:0] DEM_UNDEFINED = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [csps_pkg::TDATA_W-1:0]    s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [csps_pkg::TDATA_W-1:0]    m_tdata;
	logic                            cfg_we = 1'b0;
	logic [csps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [csps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	cap_sensor_poll_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer copy used for prediction
	csps_pkg::cfg_t   model_cfg;
	csps_pkg::phase_t seq_phase;
	logic [1:0]  cur_mode;
	logic [1:0]  prev_cap_mode;
	logic [7:0]  conv_count;
	logic        cap_up;
	logic        hum_up;
	logic        exp_ready;
	logic        rdy_latch;
	logic [1:0]  applied_dem [3];
	logic [15:0] rdy_ticks;
	logic [15:0] hum_ticks;

	csps_pkg::result_t pending_commands [$];
	logic [1:0]  demand_now [3];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int error_count = 0;
	int mismatch_reports = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int settings_used = 0;
	int pulses_seen = 0;
	int cmd_seen [8];
	bit running = 1'b0;

	task automatic reset_model();
		model_cfg = '{sensor_enable: 1'b1, single_ended_enable: 1'b0,
			temp_interleave_count: 8'd16, ready_timeout_ticks: 16'd20,
			humidity_period_ticks: 16'd100, conversion_speed: csps_pkg::SPEED_SLOW};
		seq_phase = csps_pkg::PH_POR;
		cur_mode = csps_pkg::MODE_DIFF;
		prev_cap_mode = csps_pkg::MODE_DIFF;
		conv_count = '0;
		cap_up = 1'b0;
		hum_up = 1'b0;
		exp_ready = 1'b0;
		rdy_latch = 1'b0;
		rdy_ticks = '0;
		hum_ticks = '0;
		for (int i = 0; i < 3; i++) begin
			applied_dem[i] = csps_pkg::DEM_UNKNOWN;
			demand_now[i] = csps_pkg::DEM_UNKNOWN;
		end
	endtask

	function automatic csps_pkg::result_t step_sequencer(csps_pkg::tick_t t);
		csps_pkg::result_t r;
		logic [1:0] dem [3];
		logic [1:0] nxt_cap_mode;
		bit         hit;
		r = '0;
		dem[0] = t.relay_a_demand;
		dem[1] = t.relay_b_demand;
		dem[2] = t.relay_c_demand;
		// latch and timers move even while the sensor is disabled
		if (t.ready_event)
			rdy_latch = 1'b1;
		rdy_ticks = (rdy_ticks == '1) ? rdy_ticks : rdy_ticks + 16'd1;
		hum_ticks = (hum_ticks == '1) ? hum_ticks : hum_ticks + 16'd1;
		if (!model_cfg.sensor_enable)
			return r;
		r.cap_connected = cap_up;
		r.hum_connected = hum_up;
		case (seq_phase)
			csps_pkg::PH_IDLE: begin
				if (cap_up) begin
					if (dem[0] != applied_dem[0] || dem[1] != applied_dem[1] ||
						dem[2] != applied_dem[2]) begin
						if (!exp_ready) begin
							r.expander_config = 1'b1;
							exp_ready = t.bus_ok;
						end
						if (exp_ready) begin
							hit = 1'b0;
							for (int i = 0; i < 3; i++) begin
								if (!hit && dem[i] != applied_dem[i]) begin
									hit = 1'b1;
									applied_dem[i] = dem[i];
									if (dem[i] == csps_pkg::DEM_SET_A ||
										dem[i] == csps_pkg::DEM_SET_B)
										r.relay_pulse = 3'(2 * i) + 3'(dem[i]);
								end
							end
						end
					end
					if (conv_count < model_cfg.temp_interleave_count)
						seq_phase = csps_pkg::PH_TCAP;
					else if (hum_ticks >= model_cfg.humidity_period_ticks)
						seq_phase = csps_pkg::PH_READTH;
					else
						seq_phase = csps_pkg::PH_TTEMP;
				end else begin
					seq_phase = csps_pkg::PH_RESET;
				end
			end
			csps_pkg::PH_RESET: begin
				rdy_latch = 1'b0;
				r.command = csps_pkg::CMD_RESET;
				cap_up = t.bus_ok;
				seq_phase = t.bus_ok ? csps_pkg::PH_INIT : csps_pkg::PH_IDLE;
			end
			csps_pkg::PH_INIT: begin
				r.command = csps_pkg::CMD_INIT;
				if (!t.bus_ok)
					cap_up = 1'b0;
				exp_ready = 1'b0;
				seq_phase = csps_pkg::PH_IDLE;
			end
			csps_pkg::PH_TCAP: begin
				rdy_latch = 1'b0;
				if (model_cfg.single_ended_enable) begin
					nxt_cap_mode = (prev_cap_mode == csps_pkg::MODE_C1) ? csps_pkg::MODE_C2 :
						(prev_cap_mode == csps_pkg::MODE_C2) ? csps_pkg::MODE_DIFF :
						csps_pkg::MODE_C1;
					cur_mode = nxt_cap_mode;
					prev_cap_mode = nxt_cap_mode;
				end else begin
					cur_mode = csps_pkg::MODE_DIFF;
				end
				r.command = csps_pkg::CMD_CAP_TRIG;
				r.conv_mode = cur_mode;
				r.conv_time_code = (model_cfg.conversion_speed >= csps_pkg::SPEED_SLOW) ?
					csps_pkg::SPEED_SLOW : model_cfg.conversion_speed;
				if (t.bus_ok) begin
					seq_phase = csps_pkg::PH_CAPWAIT;
				end else begin
					cap_up = 1'b0;
					seq_phase = csps_pkg::PH_IDLE;
				end
				rdy_ticks = '0;
			end
			csps_pkg::PH_CAPWAIT, csps_pkg::PH_TEMPWAIT: begin
				if (rdy_ticks >= model_cfg.ready_timeout_ticks) begin
					seq_phase = csps_pkg::PH_POR;
				end else if (rdy_latch) begin
					r.command = csps_pkg::CMD_READ;
					r.conv_mode = cur_mode;
					if (seq_phase == csps_pkg::PH_CAPWAIT && conv_count < csps_pkg::COUNT_MAX)
						conv_count = conv_count + 8'd1;
					seq_phase = csps_pkg::PH_IDLE;
				end
			end
			csps_pkg::PH_TTEMP: begin
				rdy_latch = 1'b0;
				conv_count = '0;
				cur_mode = csps_pkg::MODE_TEMP;
				r.command = csps_pkg::CMD_TEMP_TRIG;
				r.conv_mode = csps_pkg::MODE_TEMP;
				if (t.bus_ok) begin
					rdy_ticks = '0;
					seq_phase = csps_pkg::PH_TEMPWAIT;
				end else begin
					cap_up = 1'b0;
					seq_phase = csps_pkg::PH_IDLE;
				end
			end
			csps_pkg::PH_READTH: begin
				if (!hum_up) begin
					r.command = csps_pkg::CMD_HUM_DET;
					hum_up = t.hum_detect_ok;
				end else begin
					r.command = csps_pkg::CMD_HUM_READ;
				end
				if (hum_up && !t.hum_read_ok)
					hum_up = 1'b0;
				hum_ticks = '0;
				seq_phase = csps_pkg::PH_IDLE;
			end
			default: begin
				cap_up = 1'b0;
				hum_up = 1'b0;
				rdy_ticks = '0;
				hum_ticks = '0;
				seq_phase = csps_pkg::PH_IDLE;
			end
		endcase
		return r;
	endfunction

	function automatic csps_pkg::tick_t mk_tick(logic rdy, logic bus, logic det, logic rd,
		logic [1:0] a, logic [1:0] b, logic [1:0] c);
		csps_pkg::tick_t t;
		t.ready_event = rdy;
		t.bus_ok = bus;
		t.hum_detect_ok = det;
		t.hum_read_ok = rd;
		t.relay_a_demand = a;
		t.relay_b_demand = b;
		t.relay_c_demand = c;
		return t;
	endfunction

	// mostly plausible ticks with slowly moving demands, a few fully random ones
	function automatic csps_pkg::tick_t random_tick();
		csps_pkg::tick_t      t;
		logic [TICK_BITS-1:0] raw;
		if ($urandom_range(99) < 8) begin
			raw = TICK_BITS'($urandom);
			t = csps_pkg::tick_t'(raw);
		end else begin
			for (int i = 0; i < 3; i++)
				if ($urandom_range(99) < 12)
					demand_now[i] = 2'($urandom_range(2));
			t = mk_tick($urandom_range(99) < 35, $urandom_range(99) < 93,
				$urandom_range(99) < 80, $urandom_range(99) < 85,
				demand_now[0], demand_now[1], demand_now[2]);
		end
		return t;
	endfunction

	task automatic send_tick(input csps_pkg::tick_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(csps_pkg::TDATA_W - csps_pkg::TICK_W){1'b0}}, t};
		do
			@(posedge clk);
		while (!s_tready);
		pending_commands.push_back(step_sequencer(t));
		ticks_sent++;
	endtask

	task automatic run_ticks(input int n);
		for (int k = 0; k < n; k++)
			send_tick(random_tick());
	endtask

	// stop offering and let every outstanding result drain
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_commands.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [csps_pkg::CFG_IDX_W-1:0] idx,
		input logic [csps_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			csps_pkg::REG_SENSOR_ENABLE:    model_cfg.sensor_enable = data[0];
			csps_pkg::REG_SINGLE_ENDED:     model_cfg.single_ended_enable = data[0];
			csps_pkg::REG_TEMP_INTERLEAVE:  model_cfg.temp_interleave_count = data[7:0];
			csps_pkg::REG_READY_TIMEOUT:    model_cfg.ready_timeout_ticks = data;
			csps_pkg::REG_HUMIDITY_PERIOD:  model_cfg.humidity_period_ticks = data;
			csps_pkg::REG_CONVERSION_SPEED: model_cfg.conversion_speed = data[1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic se, input logic [7:0] il,
		input logic [15:0] tmo, input logic [15:0] hp, input logic [1:0] sp);
		write_reg(csps_pkg::REG_SINGLE_ENDED, DATA_BITS'(se));
		write_reg(csps_pkg::REG_TEMP_INTERLEAVE, DATA_BITS'(il));
		write_reg(csps_pkg::REG_READY_TIMEOUT, tmo);
		write_reg(csps_pkg::REG_HUMIDITY_PERIOD, hp);
		write_reg(csps_pkg::REG_CONVERSION_SPEED, DATA_BITS'(sp));
		settings_used++;
	endtask

	function automatic void check_result(csps_pkg::result_t got);
		csps_pkg::result_t want;
		bit                bad;
		results_checked++;
		cmd_seen[got.command]++;
		if (got.relay_pulse != csps_pkg::PULSE_NONE)
			pulses_seen++;
		if (pending_commands.size() == 0) begin
			error_count++;
			if (mismatch_reports < MAX_REPORTS) begin
				mismatch_reports++;
				$display("%0t: unexpected result %h with nothing outstanding", $realtime, got);
			end
			return;
		end
		want = pending_commands.pop_front();
		bad = (got.command != want.command) || (got.conv_mode != want.conv_mode) ||
			(got.conv_time_code != want.conv_time_code) ||
			(got.relay_pulse != want.relay_pulse) ||
			(got.expander_config != want.expander_config) ||
			(got.cap_connected != want.cap_connected) ||
			(got.hum_connected != want.hum_connected);
		if (bad) begin
			error_count++;
			if (mismatch_reports < MAX_REPORTS) begin
				mismatch_reports++;
				$display("%0t: result %0d mismatch cmd %0d/%0d mode %0d/%0d tcode %0d/%0d",
					$realtime, results_checked, want.command, got.command,
					want.conv_mode, got.conv_mode, want.conv_time_code, got.conv_time_code);
				$display("  pulse %0d/%0d cfg %0d/%0d cap %0d/%0d hum %0d/%0d (exp/act)",
					want.relay_pulse, got.relay_pulse, want.expander_config,
					got.expander_config, want.cap_connected, got.cap_connected,
					want.hum_connected, got.hum_connected);
			end
		end
	endfunction

	// result side: checks each transfer, stalls at random or for a requested hold-off
	always @(posedge clk) begin
		int hold_left;
		if (m_tvalid && m_tready)
			check_result(csps_pkg::result_t'(m_tdata[csps_pkg::RESULT_W-1:0]));
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		int quiet_cycles;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else if (running)
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// walks power-up, reset and init failures, the expander retry, relay pulses,
	// the humidity detect, a temperature step and a ready timeout
	task automatic test_directed_sequence();
		csps_pkg::tick_t seq [$];
		load_settings(1'b1, 8'd1, 16'd3, 16'd2, 2'd3);
		seq = '{
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b0, 1'b0, 1'b1, 1'b1, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b0, 1'b0, 1'b1, 1'b1, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b0, 1'b0, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b1, 1'b1, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b1, 1'b1, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b0, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b0, 1'b1, 1'b1, 1'b1, DM_A, DM_B, DEM_UNDEFINED),
			mk_tick(1'b1, 1'b1, 1'b1, 1'b1, DM_B, DM_A, DM_B),
			mk_tick(1'b1, 1'b1, 1'b1, 1'b1, DM_B, DM_B, DM_B),
			mk_tick(1'b0, 1'b0, 1'b0, 1'b0, DM_UNK, DM_UNK, DM_UNK),
			mk_tick(1'b1, 1'b1, 1'b1, 1'b1, DM_B, DM_B, DM_B),
			mk_tick(1'b1, 1'b1, 1'b1, 1'b1, DM_B, DM_B, DM_B)
		};
		foreach (seq[i])
			send_tick(seq[i]);
		wait_drained();
	endtask

	task automatic test_default_settings();
		write_reg(csps_pkg::REG_SENSOR_ENABLE, DATA_BITS'(1));
		load_settings(1'b0, 8'd16, 16'd20, 16'd100, csps_pkg::SPEED_SLOW);
		run_ticks(385);
		wait_drained();
	endtask

	task automatic test_fast_single_ended();
		load_settings(1'b1, 8'd1, 16'd1, 16'd1, 2'd0);
		run_ticks(230);
		wait_drained();
	endtask

	task automatic test_slow_extremes();
		load_settings(1'b1, 8'd255, 16'hFFFF, 16'hFFFF, 2'd1);
		run_ticks(230);
		wait_drained();
	endtask

	// zero interleave never triggers capacitance, zero timeout and period expire at once
	task automatic test_zero_registers();
		load_settings(1'b1, 8'd0, 16'd0, 16'd0, 2'd3);
		run_ticks(110);
		wait_drained();
		write_reg(csps_pkg::REG_TEMP_INTERLEAVE, DATA_BITS'(1));
		run_ticks(110);
		wait_drained();
	endtask

	task automatic test_sensor_disable();
		load_settings(1'b1, 8'd3, 16'd8, 16'd30, csps_pkg::SPEED_SLOW);
		run_ticks(60);
		wait_drained();
		write_reg(csps_pkg::REG_SENSOR_ENABLE, DATA_BITS'(0));
		run_ticks(70);
		wait_drained();
		write_reg(csps_pkg::REG_SENSOR_ENABLE, DATA_BITS'(1));
		run_ticks(150);
		wait_drained();
	endtask

	// result side holds off while ticks keep coming, so the input has to stall
	task automatic test_output_stall();
		hold_req = HOLD_OFF_CYCLES;
		run_ticks(60);
		wait_drained();
	endtask

	task automatic test_sender_pause();
		for (int k = 0; k < 6; k++) begin
			run_ticks(20);
			wait_drained();
		end
	endtask

	initial begin
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;

		send_idle_pct = 6;
		recv_idle_pct = 47;
		test_directed_sequence();
		test_default_settings();
		test_fast_single_ended();

		send_idle_pct = 47;
		recv_idle_pct = 6;
		test_slow_extremes();
		test_zero_registers();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_stall();
		test_sensor_disable();
		test_sender_pause();

		wait_drained();
		repeat (4) @(posedge clk);
		if (pending_commands.size() != 0)
			error_count++;
		$display("run covered %0d ticks under %0d register settings, %0d results checked",
			ticks_sent, settings_used, results_checked);
		$display("reset %0d init %0d cap trig %0d temp trig %0d read %0d",
			cmd_seen[csps_pkg::CMD_RESET], cmd_seen[csps_pkg::CMD_INIT],
			cmd_seen[csps_pkg::CMD_CAP_TRIG], cmd_seen[csps_pkg::CMD_TEMP_TRIG],
			cmd_seen[csps_pkg::CMD_READ],
			"  hum det %0d hum rd %0d pulses %0d",
			cmd_seen[csps_pkg::CMD_HUM_DET], cmd_seen[csps_pkg::CMD_HUM_READ], pulses_seen);
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
